// ----- rtl/gdo_pkg.sv -----
package gdo_pkg;

  // Field widths
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFFS_W  = 17;

  // Working year: signed, with headroom for walking past either end of the range
  localparam int WYEAR_W = 16;

  // Residue of the year modulo 400
  localparam int R400_W = 9;

  localparam logic [MONTH_W-1:0] JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DEC = MONTH_W'(12);

  localparam logic [R400_W-1:0] R400_LAST = R400_W'(399);

  localparam int YEAR_MAX = 9999;

  typedef logic [DAY_W-1:0] mlen_t [12];

  localparam mlen_t MONTH_LEN_COMMON = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };
  localparam mlen_t MONTH_LEN_LEAP = '{
    5'd31, 5'd29, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Controller to datapath
  typedef struct packed {
    logic load;     // take a new input beat
    logic step;     // walk one month
    logic capture;  // write the output register
  } gdo_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;     // day lies within its month
    logic oor;      // working year outside 0..9999
  } gdo_stat_t;

  // Year modulo 400, restoring subtraction of 400 << k
  function automatic logic [R400_W-1:0] year_mod400(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] rem;
    logic [YEAR_W-1:0] sub;
    rem = y;
    for (int k = 5; k >= 0; k--) begin
      sub = YEAR_W'(400 << k);
      if (rem >= sub) begin
        rem = rem - sub;
      end
    end
    return rem[R400_W-1:0];
  endfunction

  // 4/100/400 rule from the residue modulo 400
  function automatic logic is_leap(input logic [R400_W-1:0] r);
    logic cent;
    cent = r inside {R400_W'(100), R400_W'(200), R400_W'(300)};
    return (r[1:0] == 2'b00) && !cent;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [MONTH_W-1:0] idx;
    idx = m - JAN;
    if (idx > MONTH_W'(11)) begin
      idx = '0;
    end
    return leap ? MONTH_LEN_LEAP[idx] : MONTH_LEN_COMMON[idx];
  endfunction

endpackage

// ----- rtl/gdo_ctrl.sv -----
module gdo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  gdo_pkg::gdo_stat_t stat,
  output gdo_pkg::gdo_cmd_t  cmd
);
  import gdo_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!stat.done) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.capture   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_capture_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> stat.done && state_r == ST_WALK)
    else $error("capture before walk finished");

  a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> !out_valid_r || !out_stall)
    else $error("capture overwrote pending result");

  a_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == ST_WALK)
    else $error("accepted beat not walked");

  a_step_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && (cmd.capture || cmd.load)))
    else $error("conflicting datapath commands");

endmodule

// ----- rtl/gdo_dpath.sv -----
module gdo_dpath #(
  parameter int MAX_OFFSET = 65535
) (
  input  logic                               clk,
  input  logic [gdo_pkg::YEAR_W-1:0]         start_year,
  input  logic [gdo_pkg::MONTH_W-1:0]        start_month,
  input  logic [gdo_pkg::DAY_W-1:0]          start_day,
  input  logic signed [gdo_pkg::OFFS_W-1:0]  day_offset,
  input  gdo_pkg::gdo_cmd_t                  cmd,
  output gdo_pkg::gdo_stat_t                 stat,
  output logic [gdo_pkg::YEAR_W-1:0]         result_year,
  output logic [gdo_pkg::MONTH_W-1:0]        result_month,
  output logic [gdo_pkg::DAY_W-1:0]          result_day,
  output logic                               out_of_range
);
  import gdo_pkg::*;

  // Offset magnitude reachable after saturation, and day accumulator width
  localparam int OFF_MAG = (MAX_OFFSET < 65536) ? MAX_OFFSET : 65536;
  localparam int DW      = $clog2(OFF_MAG + 32) + 1;
  localparam int SW      = OFFS_W + 1;

  logic signed [WYEAR_W-1:0] year_r, year_nxt;
  logic [MONTH_W-1:0]        month_r, month_nxt;
  logic signed [DW-1:0]      day_r, day_nxt;
  logic [R400_W-1:0]         r400_r, r400_nxt;

  logic [YEAR_W-1:0]  ryear_r;
  logic [MONTH_W-1:0] rmonth_r;
  logic [DAY_W-1:0]   rday_r;
  logic               roor_r;

  logic signed [SW-1:0] off_ext, off_sat, lim;
  logic [MONTH_W-1:0]   m_clamp, m_prev;
  logic                 leap;
  logic signed [DW-1:0] len_cur, len_prev;
  logic                 fwd, bwd;

  assign lim     = SW'(OFF_MAG);
  assign off_ext = SW'(day_offset);

  always_comb begin
    off_sat = off_ext;
    if (off_ext > lim) begin
      off_sat = lim;
    end else if (off_ext < -lim) begin
      off_sat = -lim;
    end
    m_clamp = start_month;
    if (start_month < JAN) begin
      m_clamp = JAN;
    end else if (start_month > DEC) begin
      m_clamp = DEC;
    end
  end

  assign leap     = is_leap(r400_r);
  assign m_prev   = (month_r == JAN) ? DEC : month_r - JAN;
  // the month before March shares this year; December is 31 days either way
  assign len_cur  = signed'(DW'(month_len(leap, month_r)));
  assign len_prev = signed'(DW'(month_len(leap, m_prev)));
  assign fwd      = day_r > len_cur;
  assign bwd      = day_r < signed'(DW'(1));

  assign stat.done = !fwd && !bwd;
  assign stat.oor  = (year_r < 0) || (year_r > WYEAR_W'(YEAR_MAX));

  always_comb begin
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    r400_nxt  = r400_r;
    if (cmd.load) begin
      year_nxt  = signed'(WYEAR_W'(start_year));
      month_nxt = m_clamp;
      day_nxt   = signed'(DW'(start_day)) + signed'(DW'(off_sat));
      r400_nxt  = year_mod400(start_year);
    end else if (cmd.step) begin
      if (fwd) begin
        day_nxt = day_r - len_cur;
        if (month_r == DEC) begin
          month_nxt = JAN;
          year_nxt  = year_r + WYEAR_W'(1);
          r400_nxt  = (r400_r == R400_LAST) ? '0 : r400_r + R400_W'(1);
        end else begin
          month_nxt = month_r + JAN;
        end
      end else begin
        day_nxt   = day_r + len_prev;
        month_nxt = m_prev;
        if (month_r == JAN) begin
          year_nxt = year_r - WYEAR_W'(1);
          r400_nxt = (r400_r == '0) ? R400_LAST : r400_r - R400_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    year_r  <= year_nxt;
    month_r <= month_nxt;
    day_r   <= day_nxt;
    r400_r  <= r400_nxt;
  end

  // Output register, saturated date when the year left the range
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      roor_r <= stat.oor;
      if (year_r < 0) begin
        ryear_r  <= '0;
        rmonth_r <= JAN;
        rday_r   <= DAY_W'(1);
      end else if (stat.oor) begin
        ryear_r  <= YEAR_W'(YEAR_MAX);
        rmonth_r <= DEC;
        rday_r   <= DAY_W'(31);
      end else begin
        ryear_r  <= year_r[YEAR_W-1:0];
        rmonth_r <= month_r;
        rday_r   <= day_r[DAY_W-1:0];
      end
    end
  end

  assign result_year  = ryear_r;
  assign result_month = rmonth_r;
  assign result_day   = rday_r;
  assign out_of_range = roor_r;

endmodule

// ----- rtl/gregorian_date_offset.sv -----
// Gregorian date offset: start date plus a signed day count.
//
// Input channel (in_valid / in_stall): one beat carries year, month, day and
// a signed day offset. The offset saturates to +/-MAX_OFFSET. Month 0 counts
// as January, 13..15 as December; a day past its month rolls forward.
// Result channel (out_valid / out_stall): one beat per input beat with the
// shifted date and out_of_range, set when the year left 0..9999 (the date
// then saturates to 0000-01-01 or 9999-12-31).
//
// Walk: once an input beat is accepted, the block walks one month per cycle
// through a single subtract/add on the day count until the day lies within
// its month, then, once the output register is free, registers the result
// together with out_valid. The next beat is accepted only when the sequencer
// is back in idle, so no date is taken while one is being walked. The output
// register holds a finished result while the receiver stalls; the next item is
// then accepted and walked, and waits in place when done.
// Reset (rst_n low, synchronous) returns to idle and drops out_valid.
module gregorian_date_offset #(
  parameter int MAX_OFFSET = 65535
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [gdo_pkg::YEAR_W-1:0]         in_start_year,
  input  logic [gdo_pkg::MONTH_W-1:0]        in_start_month,
  input  logic [gdo_pkg::DAY_W-1:0]          in_start_day,
  input  logic signed [gdo_pkg::OFFS_W-1:0]  in_day_offset,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gdo_pkg::YEAR_W-1:0]         out_result_year,
  output logic [gdo_pkg::MONTH_W-1:0]        out_result_month,
  output logic [gdo_pkg::DAY_W-1:0]          out_result_day,
  output logic                               out_out_of_range
);
  import gdo_pkg::*;

  gdo_cmd_t  cmd;
  gdo_stat_t stat;

  // Sequencer: idle / walk, owns the result valid flag
  gdo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Date registers, month-length table, output register
  gdo_dpath #(
    .MAX_OFFSET (MAX_OFFSET)
  ) u_dpath (
    .clk          (clk),
    .start_year   (in_start_year),
    .start_month  (in_start_month),
    .start_day    (in_start_day),
    .day_offset   (in_day_offset),
    .cmd          (cmd),
    .stat         (stat),
    .result_year  (out_result_year),
    .result_month (out_result_month),
    .result_day   (out_result_day),
    .out_of_range (out_out_of_range)
  );

endmodule

// ----- dv/tb_gregorian_date_offset.sv -----
module tb_gregorian_date_offset;
  timeunit 1ns;
  timeprecision 1ps;

  import gdo_pkg::*;

  // Saturation bound of the offset; matches the block's default parameter
  localparam int MAX_OFFSET = 65535;
  localparam int CLK_HALF   = 5;
  // Percentage of cycles in which a side idles while gaps are enabled
  localparam int IDLE_PCT   = 11;
  // Cycles to linger after the last result
  localparam int DRAIN_CYC  = 20;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [YEAR_W-1:0]          in_start_year = '0;
  logic [MONTH_W-1:0]         in_start_month = '0;
  logic [DAY_W-1:0]           in_start_day = '0;
  logic signed [OFFS_W-1:0]   in_day_offset = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [YEAR_W-1:0]          out_result_year;
  logic [MONTH_W-1:0]         out_result_month;
  logic [DAY_W-1:0]           out_result_day;
  logic                       out_out_of_range;

  // One shifted date as the block should return it
  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               oor;
  } date_result_t;

  date_result_t expected_dates[$];

  int  error_count   = 0;
  int  dates_sent    = 0;
  int  dates_checked = 0;
  int  oor_expected  = 0;
  // Random idling on both channels; cleared for the no-gap stretch
  bit  gaps_on       = 1'b0;

  gregorian_date_offset #(
    .MAX_OFFSET(MAX_OFFSET)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_year   (in_start_year),
    .in_start_month  (in_start_month),
    .in_start_day    (in_start_day),
    .in_day_offset   (in_day_offset),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_year (out_result_year),
    .out_result_month(out_result_month),
    .out_result_day  (out_result_day),
    .out_out_of_range(out_out_of_range)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------

  // 4/100/400 rule; the working year may go negative, so residues are
  // folded into 0..n-1 before testing
  function automatic bit leap_year(int y);
    int r4, r100, r400;
    r4   = ((y % 4) + 4) % 4;
    r100 = ((y % 100) + 100) % 100;
    r400 = ((y % 400) + 400) % 400;
    return ((r4 == 0) && (r100 != 0)) || (r400 == 0);
  endfunction

  function automatic int month_days(int y, int m);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Start date plus signed offset, one month per loop pass like the block
  function automatic date_result_t shift_date(logic [YEAR_W-1:0] sy,
                                              logic [MONTH_W-1:0] sm,
                                              logic [DAY_W-1:0] sd,
                                              logic signed [OFFS_W-1:0] soff);
    date_result_t r;
    int y, m, d, off;
    y   = sy;
    m   = sm;
    d   = sd;
    off = soff;
    // only -2^16 can exceed the bound at the default width
    if (off > MAX_OFFSET) off = MAX_OFFSET;
    if (off < -MAX_OFFSET) off = -MAX_OFFSET;
    // month 0 reads as January, 13..15 as December
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    d += off;
    // forward normalization also catches a start day past its month end
    while (d > month_days(y, m)) begin
      d -= month_days(y, m);
      m++;
      if (m > 12) begin
        m = 1;
        y++;
      end
    end
    // a day of zero or less borrows from the months before
    while (d < 1) begin
      m--;
      if (m < 1) begin
        m = 12;
        y--;
      end
      d += month_days(y, m);
    end
    r.oor = 1'b0;
    if (y < 0) begin
      r.oor = 1'b1;
      y = 0;
      m = 1;
      d = 1;
    end else if (y > YEAR_MAX) begin
      r.oor = 1'b1;
      y = YEAR_MAX;
      m = 12;
      d = 31;
    end
    r.year  = YEAR_W'(y);
    r.month = MONTH_W'(m);
    r.day   = DAY_W'(d);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: one beat per call, expectation queued at acceptance
  // ---------------------------------------------------------------------
  task automatic send_date(int year, int month, int day, int offset);
    logic [YEAR_W-1:0]        y;
    logic [MONTH_W-1:0]       m;
    logic [DAY_W-1:0]         d;
    logic signed [OFFS_W-1:0] o;
    date_result_t             want;
    y = YEAR_W'(year);
    m = MONTH_W'(month);
    d = DAY_W'(day);
    o = OFFS_W'(offset);
    // random idle cycles ahead of the beat
    while (gaps_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_start_year  <= y;
    in_start_month <= m;
    in_start_day   <= d;
    in_day_offset  <= o;
    do @(posedge clk); while (in_stall);
    want = shift_date(y, m, d, o);
    expected_dates.push_back(want);
    dates_sent++;
    if (want.oor) oor_expected++;
  endtask

  function automatic int signed_rand(int max_mag);
    int v;
    v = $urandom_range(max_mag);
    return $urandom_range(1) ? -v : v;
  endfunction

  // A calendar-valid start date in the given year span
  task automatic send_valid_date(int year_lo, int year_hi, int max_off);
    int y, m, d;
    y = $urandom_range(year_hi, year_lo);
    m = $urandom_range(12, 1);
    d = $urandom_range(month_days(y, m), 1);
    send_date(y, m, d, signed_rand(max_off));
  endtask

  // ---------------------------------------------------------------------
  // Result channel: backpressure and checking
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    date_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        $error("result beat with no date pending: %0d-%0d-%0d oor=%0b",
               out_result_year, out_result_month, out_result_day, out_out_of_range);
        error_count++;
      end else begin
        want = expected_dates.pop_front();
        dates_checked++;
        if (out_result_year !== want.year) begin
          $error("result_year: expected %0d, got %0d", want.year, out_result_year);
          error_count++;
        end
        if (out_result_month !== want.month) begin
          $error("result_month: expected %0d, got %0d", want.month, out_result_month);
          error_count++;
        end
        if (out_result_day !== want.day) begin
          $error("result_day: expected %0d, got %0d", want.day, out_result_day);
          error_count++;
        end
        if (out_out_of_range !== want.oor) begin
          $error("out_of_range: expected %0b, got %0b", want.oor, out_out_of_range);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Field extremes and the calendar corner cases, back to back
  task automatic test_directed();
    send_date(2024, 1, 15, 0);
    send_date(0, 1, 1, 0);              // earliest date
    send_date(0, 1, 1, -1);             // walks below year 0
    send_date(9999, 12, 31, 0);         // latest date
    send_date(9999, 12, 31, 1);         // walks past 9999
    send_date(2000, 2, 28, 1);          // 400-year leap
    send_date(1900, 2, 28, 1);          // century, not leap
    send_date(2100, 3, 1, -1);          // backward into a short February
    send_date(2024, 2, 29, 365);
    send_date(2023, 2, 31, 0);          // day past month end, no offset
    send_date(2023, 2, 30, -1);         // still past the end after a step back
    send_date(2023, 3, 0, 0);           // day zero borrows from February
    send_date(2000, 3, 0, 0);
    send_date(2023, 0, 15, 0);          // month 0 reads as January
    send_date(2023, 13, 1, 0);          // month 13 reads as December
    send_date(2023, 15, 31, 1);
    send_date(5000, 6, 15, 65535);      // largest forward walk
    send_date(5000, 6, 15, -65535);     // largest backward walk
    send_date(5000, 6, 15, -65536);     // offset saturates
    send_date(16383, 1, 1, 0);          // start year above range
    send_date(16383, 15, 31, 65535);
    send_date(10000, 1, 1, -1);         // back into range
    send_date(100, 3, 1, -65535);       // far below year 0
    send_date(9900, 1, 1, 65535);       // far above 9999
    send_date(0, 0, 0, 0);              // all-zero beat
  endtask

  // Valid dates over the whole span, mostly short walks
  task automatic test_random_dates(int count);
    repeat (count) begin
      if ($urandom_range(9) == 0) begin
        send_valid_date(0, YEAR_MAX, MAX_OFFSET);
      end else begin
        send_valid_date(0, YEAR_MAX, 1500);
      end
    end
  endtask

  // Years near both ends, plus raw field noise; no idling on either side
  task automatic test_range_edges(int count);
    repeat (count) begin
      case ($urandom_range(3))
        0: send_valid_date(0, 3, 2000);
        1: send_valid_date(YEAR_MAX - 3, YEAR_MAX, 2000);
        2: send_date($urandom_range(16383), $urandom_range(15), $urandom_range(31),
                     signed_rand(400));
        default: send_date($urandom_range(16383, 9990), $urandom_range(15),
                           $urandom_range(31), signed_rand(20000));
      endcase
    end
  endtask

  // Raw 17-bit offsets over raw fields: long walks and saturation
  task automatic test_long_offsets(int count);
    logic [31:0] raw;
    repeat (count) begin
      raw = $urandom();
      send_date($urandom_range(16383), $urandom_range(15), $urandom_range(31),
                int'($signed(raw[OFFS_W-1:0])));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    gaps_on = 1'b1;
    test_random_dates(150);
    gaps_on = 1'b0;
    test_range_edges(60);
    gaps_on = 1'b1;
    test_long_offsets(40);

    in_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Checked %0d of %0d date shifts, %0d of them out of range,",
             dates_checked, dates_sent, oor_expected);
    $display("covering leap rules, month/day normalization and offset saturation.");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 6 ms of full walks)
  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
